/* hw/rtl/kcdl_pkg.sv */
// Shared codes and reset values of the key click, double-click and long-press detector.
package kcdl_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned KindWidth = 2;
  localparam int unsigned KeyWidth = 2;
  localparam int unsigned StampInWidth = 32;

  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_DOUBLE_GAP = 2'd2;

  localparam logic [CfgWidth-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CfgWidth-1:0] LONG_PRESS_RESET = 16'd800;
  localparam logic [CfgWidth-1:0] DOUBLE_GAP_RESET = 16'd300;

  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_CONFIRM = 2'd1;
  localparam logic [1:0] PH_PRESSING = 2'd2;
  localparam logic [1:0] PH_LONG = 2'd3;

  localparam logic [KindWidth-1:0] EV_NONE = 2'd0;
  localparam logic [KindWidth-1:0] EV_SINGLE = 2'd1;
  localparam logic [KindWidth-1:0] EV_DOUBLE = 2'd2;
  localparam logic [KindWidth-1:0] EV_LONG = 2'd3;

endpackage

/* hw/rtl/key_click_double_long_detector.sv */
// Key click, double-click and long-press detector: one poll word in, one event word out.
//
// Each poll word carries a millisecond timestamp and the pressed level of every key. The
// word is held in an input register; from there all keys are evaluated in parallel,
// the lowest-indexed key that produces an event wins and later keys keep their state, and
// the event lands in the output register. The block takes one poll word per cycle while
// the output side is ready; a single evaluation stage lies between the two registers.
// Time differences wrap modulo 2^TIME_BITS. The user must write thresholds through the
// configuration port only while idle; the block itself does not enforce this.
module key_click_double_long_detector #(
  parameter int unsigned NUM_KEYS = 4,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [kcdl_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [kcdl_pkg::CfgWidth-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [kcdl_pkg::StampInWidth-1:0]     now_ms_i,
  input  logic [NUM_KEYS-1:0]                   pressed_mask_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [kcdl_pkg::KindWidth-1:0]        event_kind_o,
  output logic [kcdl_pkg::KeyWidth-1:0]         event_key_o
);

  logic [kcdl_pkg::CfgWidth-1:0] debounce_q, long_press_q, double_gap_q;

  logic                                in_valid_q;
  logic [kcdl_pkg::StampInWidth-1:0]   now_q;
  logic [NUM_KEYS-1:0]                 mask_q;

  logic                                out_valid_q;
  logic [kcdl_pkg::KindWidth-1:0]      kind_q, kind_d;
  logic [kcdl_pkg::KeyWidth-1:0]       key_q, key_d;

  logic [1:0]           phase_q [NUM_KEYS];
  logic [1:0]           phase_d [NUM_KEYS];
  logic                 pend_q [NUM_KEYS];
  logic                 pend_d [NUM_KEYS];
  logic [TIME_BITS-1:0] press_q [NUM_KEYS];
  logic [TIME_BITS-1:0] press_d [NUM_KEYS];
  logic [TIME_BITS-1:0] rel_q [NUM_KEYS];
  logic [TIME_BITS-1:0] rel_d [NUM_KEYS];

  logic process;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] deb_w, long_w, gap_w;

  assign process = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || process;
  assign out_valid_o = out_valid_q;
  assign event_kind_o = kind_q;
  assign event_key_o = key_q;

  assign now_w = TIME_BITS'(now_q);
  assign deb_w = TIME_BITS'(debounce_q);
  assign long_w = TIME_BITS'(long_press_q);
  assign gap_w = TIME_BITS'(double_gap_q);

  always_comb begin
    logic                           hit;
    logic [kcdl_pkg::KindWidth-1:0] ev;
    logic [1:0]                     ph;
    logic                           pn;
    logic [TIME_BITS-1:0]           ps;
    logic [TIME_BITS-1:0]           rs;
    logic [TIME_BITS-1:0]           el_rel;
    logic [TIME_BITS-1:0]           el_prs;
    hit = 1'b0;
    kind_d = kcdl_pkg::EV_NONE;
    key_d = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ph = phase_q[k];
      pn = pend_q[k];
      ps = press_q[k];
      rs = rel_q[k];
      ev = kcdl_pkg::EV_NONE;
      el_rel = now_w - rel_q[k];
      el_prs = now_w - press_q[k];
      unique case (phase_q[k])
        kcdl_pkg::PH_RELEASED: begin
          if (pend_q[k] && (el_rel > gap_w)) begin
            pn = 1'b0;
            ev = kcdl_pkg::EV_SINGLE;
          end else if (mask_q[k]) begin
            ps = now_w;
            ph = kcdl_pkg::PH_CONFIRM;
          end
        end
        kcdl_pkg::PH_CONFIRM: begin
          if (mask_q[k]) begin
            if (el_prs >= deb_w) begin
              ps = now_w;
              ph = kcdl_pkg::PH_PRESSING;
            end
          end else begin
            ph = kcdl_pkg::PH_RELEASED;
          end
        end
        kcdl_pkg::PH_PRESSING: begin
          if (!mask_q[k]) begin
            ph = kcdl_pkg::PH_RELEASED;
            if (pend_q[k] && (el_rel <= gap_w)) begin
              pn = 1'b0;
              ev = kcdl_pkg::EV_DOUBLE;
            end else begin
              pn = 1'b1;
              rs = now_w;
            end
          end else if (el_prs >= long_w) begin
            ph = kcdl_pkg::PH_LONG;
          end
        end
        default: begin
          if (!mask_q[k]) begin
            ph = kcdl_pkg::PH_RELEASED;
            pn = 1'b0;
            ev = kcdl_pkg::EV_LONG;
          end
        end
      endcase
      if (process && !hit) begin
        phase_d[k] = ph;
        pend_d[k] = pn;
        press_d[k] = ps;
        rel_d[k] = rs;
      end else begin
        phase_d[k] = phase_q[k];
        pend_d[k] = pend_q[k];
        press_d[k] = press_q[k];
        rel_d[k] = rel_q[k];
      end
      if (!hit && (ev != kcdl_pkg::EV_NONE)) begin
        kind_d = ev;
        key_d = kcdl_pkg::KeyWidth'(k);
        hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kcdl_pkg::DEBOUNCE_RESET;
      long_press_q <= kcdl_pkg::LONG_PRESS_RESET;
      double_gap_q <= kcdl_pkg::DOUBLE_GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kcdl_pkg::CFG_DEBOUNCE:   debounce_q <= cfg_wdata_i;
        kcdl_pkg::CFG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        kcdl_pkg::CFG_DOUBLE_GAP: double_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (process) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q <= now_ms_i;
      mask_q <= pressed_mask_i;
    end
    if (process) begin
      kind_q <= kind_d;
      key_q <= key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_q[k] <= kcdl_pkg::PH_RELEASED;
        pend_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_q[k] <= phase_d[k];
        pend_q[k] <= pend_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      press_q[k] <= press_d[k];
      rel_q[k] <= rel_d[k];
    end
  end

endmodule
